@@ rtl/mqtt_receive_packet_parser_defines.svh @@
// assertion macros shared by the parser modules
`ifndef MQTT_RECEIVE_PACKET_PARSER_DEFINES_SVH
`define MQTT_RECEIVE_PACKET_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define MQTTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MQTTP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MQTTP_ASSERT(lbl, prop, msg)
`define MQTTP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/mqttp_pkg.sv @@
`timescale 1ns / 1ps

package mqttp_pkg;

	localparam int MaxLengthBytes = 4;
	localparam int QueueDepth     = 4;
	localparam int RemLenW        = 28;
	localparam int LenShiftW      = 5;

	// control packet types from the fixed header
	localparam logic [3:0] PT_RESERVED    = 4'd0;
	localparam logic [3:0] PT_CONNECT     = 4'd1;
	localparam logic [3:0] PT_CONNACK     = 4'd2;
	localparam logic [3:0] PT_PUBLISH     = 4'd3;
	localparam logic [3:0] PT_PUBACK      = 4'd4;
	localparam logic [3:0] PT_PUBREC      = 4'd5;
	localparam logic [3:0] PT_PUBREL      = 4'd6;
	localparam logic [3:0] PT_PUBCOMP     = 4'd7;
	localparam logic [3:0] PT_SUBACK      = 4'd9;
	localparam logic [3:0] PT_UNSUBACK    = 4'd11;
	localparam logic [3:0] PT_PINGREQ     = 4'd12;
	localparam logic [3:0] PT_PINGRESP    = 4'd13;
	localparam logic [3:0] PT_FORBIDDEN   = 4'd15;

	// first bytes of the replies we send, and their length byte
	localparam logic [7:0] REPLY_PUBACK   = 8'h40;
	localparam logic [7:0] REPLY_PUBREC   = 8'h50;
	localparam logic [7:0] REPLY_PUBREL   = 8'h62;
	localparam logic [7:0] REPLY_PUBCOMP  = 8'h70;
	localparam logic [7:0] REPLY_LEN      = 8'h02;

	// modem text that can show up in place of a packet
	localparam logic [7:0] MODEM_C        = 8'h43;
	localparam logic [7:0] MODEM_L        = 8'h4C;
	localparam logic [7:0] MODEM_PLUS     = 8'h2B;
	localparam logic [7:0] MODEM_P        = 8'h50;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_BODY   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		KIND_TOPIC    = 3'd0,
		KIND_MESSAGE  = 3'd1,
		KIND_REPLY    = 3'd2,
		KIND_CONNACK  = 3'd3,
		KIND_PINGRESP = 3'd4,
		KIND_DROP     = 3'd5,
		KIND_PUB_END  = 3'd6,
		KIND_ACK      = 3'd7
	} kind_t;

	// what one input byte asks of the output side: an optional data byte,
	// an optional four byte reply and an optional status item, in that order
	typedef struct packed {
		logic       byte_v;
		kind_t      byte_kind;
		logic [7:0] byte_data;
		logic       reply_v;
		logic [7:0] reply_first;
		logic       tail_v;
		kind_t      tail_kind;
		logic [7:0] tail_data;
		logic [15:0] id;
	} desc_t;

endpackage

@@ rtl/mqttp_front.sv @@
`timescale 1ns / 1ps
`include "mqtt_receive_packet_parser_defines.svh"

module mqttp_front
	import mqttp_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = MaxLengthBytes
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	output logic       push,
	output desc_t      desc
);

	localparam int LcW = $clog2(MAX_LENGTH_BYTES + 1);

	logic                 link_q, link_d;
	phase_t               phase_q, phase_d;
	logic [3:0]           pk_q, pk_d;
	logic [1:0]           qos_q, qos_d;
	logic [7:0]           hdr_q, hdr_d;
	logic [RemLenW-1:0]   rem_q, rem_d;
	logic [LcW-1:0]       lcnt_q, lcnt_d;
	logic [RemLenW-1:0]   bc_q, bc_d;
	logic [15:0]          tl_q, tl_d;
	logic [15:0]          id_q, id_d;

	logic [3:0]           hdr_type;
	logic                 hdr_ok;
	logic                 modem;
	logic [LenShiftW-1:0] shift;
	logic [RemLenW-1:0]   rem_n;
	logic                 len_end;
	logic [RemLenW-1:0]   bc_n;
	logic                 body_end;
	logic [16:0]          tl2;
	logic [17:0]          tl4;
	logic                 in_topic;
	logic                 in_id;
	logic [15:0]          body_id;

	function automatic desc_t finish_desc(input logic [3:0] pk, input logic [1:0] qos,
			input logic [15:0] id, input desc_t base);
		desc_t d;
		d = base;
		unique case (pk)
			PT_CONNACK: begin
				d.tail_v    = 1'b1;
				d.tail_kind = KIND_CONNACK;
			end
			PT_PUBLISH: begin
				d.reply_v     = (qos == 2'd1) || (qos == 2'd2);
				d.reply_first = (qos == 2'd1) ? REPLY_PUBACK : REPLY_PUBREC;
				d.tail_v      = 1'b1;
				d.tail_kind   = KIND_PUB_END;
				d.tail_data   = {6'd0, qos};
				d.id          = id;
			end
			PT_PUBREC: begin
				d.reply_v     = 1'b1;
				d.reply_first = REPLY_PUBREL;
				d.id          = id;
			end
			PT_PUBREL: begin
				d.reply_v     = 1'b1;
				d.reply_first = REPLY_PUBCOMP;
				d.id          = id;
			end
			PT_PUBACK, PT_PUBCOMP, PT_SUBACK, PT_UNSUBACK: begin
				d.tail_v    = 1'b1;
				d.tail_kind = KIND_ACK;
				d.id        = id;
			end
			PT_PINGREQ: begin
				d.tail_v    = 1'b1;
				d.tail_kind = KIND_DROP;
			end
			PT_PINGRESP: begin
				d.tail_v    = 1'b1;
				d.tail_kind = KIND_PINGRESP;
			end
			default: ;
		endcase
		return d;
	endfunction

	assign hdr_type = rx_byte[7:4];
	assign hdr_ok   = (hdr_type != PT_RESERVED) && (hdr_type != PT_FORBIDDEN);
	assign modem    = (rem_q == '0) &&
		(((hdr_q == MODEM_C) && (rx_byte == MODEM_L)) ||
		 ((hdr_q == MODEM_PLUS) && (rx_byte == MODEM_P)));
	assign shift    = LenShiftW'(lcnt_q * 7);
	assign rem_n    = rem_q | ({{(RemLenW-7){1'b0}}, rx_byte[6:0]} << shift);
	assign len_end  = !rx_byte[7] || (lcnt_q == LcW'(MAX_LENGTH_BYTES - 1));
	assign bc_n     = bc_q + RemLenW'(1);
	assign body_end = bc_n >= rem_q;
	// topic bytes sit at body offsets 2 .. tl+1, the publish id right after when qos is nonzero
	assign tl2      = {1'b0, tl_q} + 17'd2;
	assign tl4      = {2'b0, tl_q} + 18'd4;
	assign in_topic = bc_q < {{(RemLenW-17){1'b0}}, tl2};
	assign in_id    = (qos_q != 2'd0) && (bc_q < {{(RemLenW-18){1'b0}}, tl4});
	assign body_id  = {id_q[7:0], rx_byte};

	// next state
	always_comb begin
		phase_d = phase_q;
		link_d  = link_q;
		if (fire) begin
			if (operation) begin
				link_d  = 1'b1;
				phase_d = PH_HEADER;
			end else if (link_q) begin
				unique case (phase_q)
					PH_HEADER: begin
						if (hdr_ok)
							phase_d = PH_LENGTH;
					end
					PH_LENGTH: begin
						if (modem) begin
							link_d  = 1'b0;
							phase_d = PH_HEADER;
						end else if (len_end) begin
							if (rem_n == '0) begin
								phase_d = PH_HEADER;
								if (pk_q == PT_PINGREQ)
									link_d = 1'b0;
							end else begin
								phase_d = PH_BODY;
							end
						end
					end
					PH_BODY: begin
						if (body_end) begin
							phase_d = PH_HEADER;
							if (pk_q == PT_PINGREQ)
								link_d = 1'b0;
						end
					end
					default: phase_d = PH_HEADER;
				endcase
			end
		end
	end

	// datapath and descriptor
	always_comb begin
		desc_t d;
		d      = '0;
		pk_d   = pk_q;
		qos_d  = qos_q;
		hdr_d  = hdr_q;
		rem_d  = rem_q;
		lcnt_d = lcnt_q;
		bc_d   = bc_q;
		tl_d   = tl_q;
		id_d   = id_q;
		if (fire && !operation && link_q) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_ok) begin
						hdr_d  = rx_byte;
						pk_d   = hdr_type;
						qos_d  = rx_byte[2:1];
						rem_d  = '0;
						lcnt_d = '0;
					end
				end
				PH_LENGTH: begin
					if (modem) begin
						d.tail_v    = 1'b1;
						d.tail_kind = KIND_DROP;
					end else begin
						rem_d = rem_n;
						if (!len_end) begin
							lcnt_d = lcnt_q + LcW'(1);
						end else begin
							bc_d = '0;
							tl_d = '0;
							id_d = '0;
							if (rem_n == '0)
								d = finish_desc(pk_q, qos_q, 16'd0, d);
						end
					end
				end
				PH_BODY: begin
					if (pk_q == PT_PUBLISH) begin
						priority if (bc_q == '0) begin
							tl_d = {rx_byte, 8'd0};
						end else if (bc_q == RemLenW'(1)) begin
							tl_d = {tl_q[15:8], tl_q[7:0] | rx_byte};
						end else if (in_topic) begin
							d.byte_v    = 1'b1;
							d.byte_kind = KIND_TOPIC;
							d.byte_data = rx_byte;
						end else if (in_id) begin
							id_d = body_id;
						end else begin
							d.byte_v    = 1'b1;
							d.byte_kind = KIND_MESSAGE;
							d.byte_data = rx_byte;
						end
					end else if (bc_q < RemLenW'(2)) begin
						id_d = body_id;
					end
					bc_d = bc_n;
					if (body_end)
						d = finish_desc(pk_q, qos_q, id_d, d);
				end
				default: ;
			endcase
		end
		desc = d;
		push = d.byte_v || d.reply_v || d.tail_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= 1'b0;
			phase_q <= PH_HEADER;
			pk_q    <= '0;
			qos_q   <= '0;
			hdr_q   <= '0;
			rem_q   <= '0;
			lcnt_q  <= '0;
			bc_q    <= '0;
			tl_q    <= '0;
			id_q    <= '0;
		end else begin
			link_q  <= link_d;
			phase_q <= phase_d;
			pk_q    <= pk_d;
			qos_q   <= qos_d;
			hdr_q   <= hdr_d;
			rem_q   <= rem_d;
			lcnt_q  <= lcnt_d;
			bc_q    <= bc_d;
			tl_q    <= tl_d;
			id_q    <= id_d;
		end
	end

	`MQTTP_ASSERT(a_body_needs_link, (phase_q != PH_HEADER) |-> link_q, "parsing with link closed")
	`MQTTP_ASSERT(a_reply_at_end, (push && desc.reply_v) |-> (phase_q != PH_HEADER), "reply outside packet end")
	`MQTTP_ASSERT(a_body_count, (fire && !operation && phase_q == PH_BODY) |=> (bc_q == $past(bc_q) + RemLenW'(1)), "body count skipped")

endmodule

@@ rtl/mqttp_fifo.sv @@
`timescale 1ns / 1ps
`include "mqtt_receive_packet_parser_defines.svh"

module mqttp_fifo
	import mqttp_pkg::*;
#(
	parameter int DEPTH = QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_data,
	input  logic  pop,
	output desc_t pop_data,
	output logic  full,
	output logic  empty
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	desc_t           mem_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign full     = cnt_q == CntW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
			if (pop)
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CntW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CntW'(1);
		end
	end

	`MQTTP_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
	`MQTTP_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")
	`MQTTP_ASSERT(a_fill, (push && !pop) |=> !empty, "queue lost an item")

endmodule

@@ rtl/mqttp_back.sv @@
`timescale 1ns / 1ps
`include "mqtt_receive_packet_parser_defines.svh"

module mqttp_back
	import mqttp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  desc_t       q_desc,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	// slot 0 data byte, slots 1 to 4 reply bytes, slot 5 status item
	logic [5:0]  mask_q, mask_d;
	desc_t       desc_q;
	logic [5:0]  mask_rest;
	logic [5:0]  mask_after;
	logic        out_fire;
	logic        load;
	kind_t       kind;
	logic [7:0]  data;
	logic [15:0] pid;

	assign mask_rest  = mask_q & (mask_q - 6'd1);
	assign out_fire   = m_tvalid && m_tready;
	assign mask_after = out_fire ? mask_rest : mask_q;
	assign load       = (mask_after == '0) && !q_empty;
	assign q_pop      = load;
	assign mask_d     = load ? {q_desc.tail_v, {4{q_desc.reply_v}}, q_desc.byte_v} : mask_after;

	assign m_tvalid = mask_q != '0;
	assign m_tlast  = mask_rest == '0;
	assign m_tuser  = kind;
	assign m_tdata  = {pid, data};

	always_comb begin
		kind = KIND_REPLY;
		data = '0;
		pid  = '0;
		priority if (mask_q[0]) begin
			kind = desc_q.byte_kind;
			data = desc_q.byte_data;
		end else if (mask_q[1]) begin
			data = desc_q.reply_first;
		end else if (mask_q[2]) begin
			data = REPLY_LEN;
		end else if (mask_q[3]) begin
			data = desc_q.id[15:8];
		end else if (mask_q[4]) begin
			data = desc_q.id[7:0];
		end else if (mask_q[5]) begin
			kind = desc_q.tail_kind;
			data = desc_q.tail_data;
			pid  = desc_q.id;
		end else begin
			kind = KIND_REPLY;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			desc_q <= q_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= '0;
		else
			mask_q <= mask_d;
	end

	`MQTTP_ASSERT(a_load_nonempty, load |=> (mask_q != '0), "queued item with no results")
	`MQTTP_ASSERT(a_hold_item, (out_fire && !m_tlast) |=> ($stable(desc_q) && mask_q != '0), "item dropped mid sequence")
	`MQTTP_ASSERT(a_pop_when_done, q_pop |-> (mask_after == '0), "pop while results pending")
	`MQTTP_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (mask_q == '0), "results pending in reset")

endmodule

@@ rtl/mqtt_receive_packet_parser.sv @@
`timescale 1ns / 1ps

// MQTT receive-side parser. Each input item is one link byte (s_tuser = 0) or a link-opened
// notice (s_tuser = 1). The front parses the fixed header, the variable length field and the
// body at one item per cycle while the queue is not full, turning each byte that has results
// into one queued entry; the back expands each entry into 1 to 6 output items (topic/message
// byte, four PUBACK/PUBREC/PUBREL/PUBCOMP reply bytes, status item) at one item per cycle
// while m_tready is high, m_tlast marking the last item of an input. An entry is registered
// in the queue, then in the back's slot mask, before its first output. Input runs at one byte
// per cycle while the output keeps up; an input with n outputs holds the back until all are
// taken, and a QUEUE_DEPTH-entry queue between the two absorbs that before s_tready drops.

module mqtt_receive_packet_parser
	import mqttp_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = MaxLengthBytes,
	parameter int QUEUE_DEPTH      = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // data[7:0], packet_id[23:8]
	output logic [2:0]  m_tuser,   // kind
	output logic        m_tlast
);

	logic  fire;
	logic  push;
	desc_t push_desc;
	desc_t head_desc;
	logic  pop;
	logic  full;
	logic  empty;

	assign s_tready = !full;
	assign fire     = s_tvalid && s_tready;

	mqttp_front #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.operation (s_tuser),
		.rx_byte   (s_tdata),
		.push      (push),
		.desc      (push_desc)
	);

	mqttp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_desc),
		.pop       (pop),
		.pop_data  (head_desc),
		.full      (full),
		.empty     (empty)
	);

	mqttp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_desc   (head_desc),
		.q_empty  (empty),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
